FILE: design/assert_macros.svh
// Shared concurrent check macros; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RHC_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_hsl_converter: check failed");

// Next-cycle implication.
`define RHC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_hsl_converter: check failed");

`endif

FILE: design/rhc_pkg.sv
package rhc_pkg;

    localparam int NUM_W      = 27;
    localparam int DEN_W      = 11;
    localparam int Q_W        = 17;
    localparam int FRONT_LAT  = 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int HSL_LAT    = 8;
    localparam int PIPE_DEPTH = FRONT_LAT + DIV_STEPS;

    typedef enum logic {
        OP_RGB2HSL = 1'b0,
        OP_HSL2RGB = 1'b1
    } op_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_lane_t;

    typedef struct packed {
        div_lane_t   sat;
        div_lane_t   hue;
        logic        gray;
        logic [15:0] light;
    } div_req_t;

    typedef struct packed {
        logic [Q_W-1:0] sat_q;
        logic [Q_W-1:0] hue_q;
        logic           gray;
        logic [15:0]    light;
    } div_rsp_t;

endpackage

FILE: design/rgb_hsl_converter.sv
// RGB <-> HSL pixel converter.
// Input channel: in_valid / in_ready carry one pixel beat with an operation
// code. OP_RGB2HSL uses red_in, green_in, blue_in; OP_HSL2RGB uses hue_in,
// sat_in, light_in. Unused input fields are ignored.
// Output channel: out_valid / out_ready carry one result beat per input beat,
// in order. Fields not produced by the operation read as zero.
// Pipeline: 20 register stages (2 front stages, 17 quotient stages of the
// divider, 1 output register).
// The HSL to RGB path is 8 stages deep and is delayed to the same latency.
// Throughput: one beat per cycle unless the receiver stalls, set by the single-step-per-stage divider.
// The pipeline advances as a whole while the output register is empty or
// being taken; when the receiver stalls with a result held, every stage holds
// and in_ready drops until out_ready returns. Bubbles move through untouched.
// Reset clears all valid bits; no beat is in flight after reset.
module rgb_hsl_converter #(
    parameter int FRACTION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [15:0] hue_in,
    input  logic [15:0] sat_in,
    input  logic [15:0] light_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [15:0] hue_out,
    output logic [15:0] sat_out,
    output logic [15:0] light_out
);

    localparam int DEPTH   = rhc_pkg::PIPE_DEPTH;
    localparam int RGB_DLY = rhc_pkg::PIPE_DEPTH - rhc_pkg::HSL_LAT;

    logic              adv;
    logic [DEPTH-1:0]  vld_reg;
    logic              out_valid_reg;
    rhc_pkg::op_t      op_reg [DEPTH];
    logic [23:0]       rgb_dly_reg [RGB_DLY];

    rhc_pkg::div_req_t req;
    rhc_pkg::div_rsp_t rsp;
    logic [7:0]        hr;
    logic [7:0]        hg;
    logic [7:0]        hb;

    rhc_pkg::op_t      out_op_reg;
    logic [7:0]        red_reg;
    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;
    logic [15:0]       hue_reg;
    logic [15:0]       sat_reg;
    logic [15:0]       light_reg;

    logic              rgb_beat;
    logic              hsl_beat;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    rhc_rgb_front u_front
    (
        .clk   (clk),
        .en    (adv),
        .red   (red_in),
        .green (green_in),
        .blue  (blue_in),
        .req   (req)
    );

    rhc_div u_div
    (
        .clk (clk),
        .en  (adv),
        .req (req),
        .rsp (rsp)
    );

    rhc_hsl2rgb #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_hsl2rgb
    (
        .clk   (clk),
        .en    (adv),
        .hue   (hue_in),
        .sat   (sat_in),
        .light (light_in),
        .red   (hr),
        .green (hg),
        .blue  (hb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], in_valid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg[0]      <= rhc_pkg::op_t'(operation);
            rgb_dly_reg[0] <= {hr, hg, hb};
            for (int i = 1; i < DEPTH; i++)
            begin
                op_reg[i] <= op_reg[i-1];
            end
            for (int i = 1; i < RGB_DLY; i++)
            begin
                rgb_dly_reg[i] <= rgb_dly_reg[i-1];
            end
            out_op_reg <= op_reg[DEPTH-1];
            if (op_reg[DEPTH-1] == rhc_pkg::OP_HSL2RGB)
            begin
                red_reg   <= rgb_dly_reg[RGB_DLY-1][23:16];
                green_reg <= rgb_dly_reg[RGB_DLY-1][15:8];
                blue_reg  <= rgb_dly_reg[RGB_DLY-1][7:0];
                hue_reg   <= '0;
                sat_reg   <= '0;
                light_reg <= '0;
            end
            else
            begin
                red_reg   <= '0;
                green_reg <= '0;
                blue_reg  <= '0;
                light_reg <= rsp.light;
                if (rsp.gray)
                begin
                    hue_reg <= '0;
                    sat_reg <= '0;
                end
                else
                begin
                    hue_reg <= rsp.hue_q[15:0];
                    sat_reg <= rsp.sat_q[rhc_pkg::Q_W-1] ? 16'hFFFF : rsp.sat_q[15:0];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign hue_out   = hue_reg;
    assign sat_out   = sat_reg;
    assign light_out = light_reg;

    assign rgb_beat = out_valid_reg && (out_op_reg == rhc_pkg::OP_RGB2HSL);
    assign hsl_beat = out_valid_reg && (out_op_reg == rhc_pkg::OP_HSL2RGB);

`include "assert_macros.svh"

    `RHC_ASSERT_NEXT(a_stall_holds_valid, !adv, $stable(vld_reg))
    `RHC_ASSERT_IMPLY(a_gray_hue_zero, rgb_beat && sat_out == 16'd0, hue_out == 16'd0)
    `RHC_ASSERT_IMPLY(a_hsl_fields_zero, hsl_beat, hue_out == '0 && sat_out == '0 && light_out == '0)
    `RHC_ASSERT_IMPLY(a_rgb_fields_zero, rgb_beat, red_out == '0 && green_out == '0 && blue_out == '0)

endmodule

FILE: design/rhc_rgb_front.sv
module rhc_rgb_front
(
    input  logic              clk,
    input  logic              en,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    output rhc_pkg::div_req_t req
);

    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         del_c;
    logic [8:0]         sum_c;
    logic [7:0]         den_c;
    logic [10:0]        del6_c;
    logic signed [11:0] num_c;
    logic [16:0]        lsum_c;

    logic [7:0]  del_reg;
    logic [7:0]  den_reg;
    logic [10:0] num_reg;
    logic [15:0] light_reg;

    rhc_pkg::div_req_t req_next;
    rhc_pkg::div_req_t req_reg;

    always_comb
    begin
        mx = red;
        mn = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        del_c  = mx - mn;
        sum_c  = {1'b0, mx} + {1'b0, mn};
        den_c  = (sum_c < 9'd255) ? sum_c[7:0] : 8'(9'd510 - sum_c);
        del6_c = {1'b0, del_c, 2'b00} + {2'b00, del_c, 1'b0};
        if (red == mx)
        begin
            num_c = $signed({4'b0000, green}) - $signed({4'b0000, blue});
        end
        else if (green == mx)
        begin
            num_c = $signed({3'b000, del_c, 1'b0}) + $signed({4'b0000, blue})
                  - $signed({4'b0000, red});
        end
        else
        begin
            num_c = $signed({2'b00, del_c, 2'b00}) + $signed({4'b0000, red})
                  - $signed({4'b0000, green});
        end
        if (num_c < 0)
        begin
            num_c = num_c + $signed({1'b0, del6_c});
        end
        lsum_c = {sum_c, 8'h00} + {8'h00, sum_c} + 17'd1;
    end

    always_comb
    begin
        req_next.sat.num = rhc_pkg::NUM_W'({del_reg, 16'h0000})
                         - rhc_pkg::NUM_W'(del_reg)
                         + rhc_pkg::NUM_W'(den_reg[7:1]);
        req_next.sat.den = rhc_pkg::DEN_W'(den_reg);
        req_next.hue.num = {num_reg, 16'h0000}
                         + rhc_pkg::NUM_W'({1'b0, del_reg, 1'b0} + {2'b00, del_reg});
        req_next.hue.den = {1'b0, del_reg, 2'b00} + {2'b00, del_reg, 1'b0};
        req_next.gray    = (del_reg == 8'd0);
        req_next.light   = light_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            del_reg   <= del_c;
            den_reg   <= den_c;
            num_reg   <= num_c[10:0];
            light_reg <= lsum_c[16:1];
            req_reg   <= req_next;
        end
    end

    assign req = req_reg;

endmodule

FILE: design/rhc_div.sv
module rhc_div
(
    input  logic              clk,
    input  logic              en,
    input  rhc_pkg::div_req_t req,
    output rhc_pkg::div_rsp_t rsp
);

    localparam int STEPS = rhc_pkg::DIV_STEPS;
    localparam int NW    = rhc_pkg::NUM_W;
    localparam int QW    = rhc_pkg::Q_W;

    rhc_pkg::div_lane_t lane_reg  [STEPS][2];
    rhc_pkg::div_lane_t lane_next [STEPS][2];
    logic [QW-1:0]      quo_reg   [STEPS][2];
    logic [QW-1:0]      quo_next  [STEPS][2];
    logic               gray_reg  [STEPS];
    logic [15:0]        light_reg [STEPS];

    always_comb
    begin
        rhc_pkg::div_lane_t src;
        logic [QW-1:0]      src_q;
        logic [NW:0]        dsh;
        logic               hit;
        for (int i = 0; i < STEPS; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                if (i == 0)
                begin
                    src   = (j == 0) ? req.sat : req.hue;
                    src_q = '0;
                end
                else
                begin
                    src   = lane_reg[i-1][j];
                    src_q = quo_reg[i-1][j];
                end
                dsh = (NW+1)'(src.den) << (STEPS - 1 - i);
                hit = ({1'b0, src.num} >= dsh);
                lane_next[i][j].den = src.den;
                lane_next[i][j].num = hit ? NW'({1'b0, src.num} - dsh) : src.num;
                quo_next[i][j]      = {src_q[QW-2:0], hit};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg     <= lane_next;
            quo_reg      <= quo_next;
            gray_reg[0]  <= req.gray;
            light_reg[0] <= req.light;
            for (int i = 1; i < STEPS; i++)
            begin
                gray_reg[i]  <= gray_reg[i-1];
                light_reg[i] <= light_reg[i-1];
            end
        end
    end

    assign rsp.sat_q = quo_reg[STEPS-1][0];
    assign rsp.hue_q = quo_reg[STEPS-1][1];
    assign rsp.gray  = gray_reg[STEPS-1];
    assign rsp.light = light_reg[STEPS-1];

endmodule

FILE: design/rhc_hsl2rgb.sv
module rhc_hsl2rgb #(
    parameter int FRACTION_BITS = 16
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] hue,
    input  logic [15:0] sat,
    input  logic [15:0] light,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    localparam int F            = FRACTION_BITS;
    localparam int W            = F + 1;
    localparam int RW           = (F + 2 > 17) ? F + 2 : 17;
    localparam int THIRD_I      = ((1 << F) + 1) / 3;
    localparam int TWO_THIRDS_I = ((2 << F) + 1) / 3;

    localparam logic [W-1:0] ONE        = W'(1) << F;
    localparam logic [W-1:0] HALF       = W'(1) << (F - 1);
    localparam logic [F-1:0] THIRD      = F'(THIRD_I);
    localparam logic [F-1:0] REST_THIRD = F'((1 << F) - THIRD_I);
    localparam logic [F-1:0] TWO_THIRDS = F'(TWO_THIRDS_I);

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } seg_t;

    function automatic logic [W-1:0] div_ffff(input logic [F+16:0] x);
        logic [W-1:0]     q0;
        logic [RW-1:0]    r1;
        logic [RW-17:0]   q1;
        logic [16:0]      r2;
        logic             corr;
        q0   = x[F+16:16];
        r1   = RW'(x[15:0]) + RW'(q0);
        q1   = r1[RW-1:16];
        r2   = 17'(r1[15:0]) + 17'(q1);
        corr = (r2 >= 17'd65535);
        return q0 + W'(q1) + W'(corr);
    endfunction

    function automatic logic [W-1:0] fx_mul(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [2*W-1:0] p;
        p = (2*W)'(a) * (2*W)'(b) + (2*W)'(HALF);
        return p[2*F:F];
    endfunction

    // stage 1
    logic [F+16:0] h_x;
    logic [F+16:0] s_x;
    logic [F+16:0] l_x;
    logic [F-1:0]  h1_reg;
    logic [W-1:0]  s1_reg;
    logic [W-1:0]  l1_reg;
    logic          gray1_reg;

    // stage 2
    logic [F-1:0] h2_reg;
    logic [W-1:0] s2_reg;
    logic [W-1:0] l2_reg;
    logic [W-1:0] ls2_reg;
    logic         gray2_reg;

    // stage 3
    logic [W:0]   sum_ls;
    logic [W:0]   hi_a;
    logic [W-1:0] hi3_next;
    logic [W-1:0] hi3_reg;
    logic [W-1:0] l3_reg;
    logic [F-1:0] t3_reg [3];
    logic         gray3_reg;

    // stage 4
    logic [W:0]   lo_a;
    logic [W-1:0] lo4_next;
    logic [W-1:0] span4_next;
    logic [W-1:0] lo4_reg;
    logic [W-1:0] hi4_reg;
    logic [W-1:0] span4_reg;
    logic [W-1:0] l4_reg;
    logic [F-1:0] t4_reg [3];
    logic         gray4_reg;

    // stage 5
    seg_t         seg5_next [3];
    logic [W-1:0] fac5_next [3];
    seg_t         seg5_reg  [3];
    logic [W-1:0] fac5_reg  [3];
    logic [W-1:0] lo5_reg;
    logic [W-1:0] hi5_reg;
    logic [W-1:0] span5_reg;
    logic [W-1:0] l5_reg;
    logic         gray5_reg;

    // stage 6
    logic [W-1:0] m6_reg  [3];
    seg_t         seg6_reg [3];
    logic [W-1:0] lo6_reg;
    logic [W-1:0] hi6_reg;
    logic [W-1:0] l6_reg;
    logic         gray6_reg;

    // stage 7
    logic [W-1:0] c7_next [3];
    logic [W-1:0] c7_reg  [3];

    // stage 8
    logic [7:0]   b8_next [3];
    logic [7:0]   b8_reg  [3];

    always_comb
    begin
        h_x = {1'b0, hue, {F{1'b0}}} + (F+17)'(32768);
        s_x = {1'b0, sat, {F{1'b0}}} + (F+17)'(32767);
        l_x = {1'b0, light, {F{1'b0}}} + (F+17)'(32767);
    end

    always_comb
    begin
        sum_ls = {1'b0, l2_reg} + {1'b0, s2_reg};
        if (l2_reg < HALF)
        begin
            hi_a = {1'b0, l2_reg} + {1'b0, ls2_reg};
        end
        else if (sum_ls > {1'b0, ls2_reg})
        begin
            hi_a = sum_ls - {1'b0, ls2_reg};
        end
        else
        begin
            hi_a = '0;
        end
        hi3_next = (hi_a > {1'b0, ONE}) ? ONE : hi_a[W-1:0];
    end

    always_comb
    begin
        if ({l3_reg, 1'b0} > {1'b0, hi3_reg})
        begin
            lo_a = {l3_reg, 1'b0} - {1'b0, hi3_reg};
        end
        else
        begin
            lo_a = '0;
        end
        lo4_next   = (lo_a > {1'b0, ONE}) ? ONE : lo_a[W-1:0];
        span4_next = (hi3_reg > lo4_next) ? hi3_reg - lo4_next : '0;
    end

    always_comb
    begin
        logic [F+2:0] t6;
        logic [F+1:0] t3x;
        logic [F-1:0] rest;
        logic [F+2:0] r6;
        for (int i = 0; i < 3; i++)
        begin
            t6   = (F+3)'({t4_reg[i], 2'b00}) + (F+3)'({t4_reg[i], 1'b0});
            t3x  = (F+2)'({t4_reg[i], 1'b0}) + (F+2)'(t4_reg[i]);
            rest = (TWO_THIRDS > t4_reg[i]) ? TWO_THIRDS - t4_reg[i] : '0;
            r6   = (F+3)'({rest, 2'b00}) + (F+3)'({rest, 1'b0});
            if (t6 < (F+3)'(ONE))
            begin
                seg5_next[i] = SEG_RISE;
                fac5_next[i] = t6[W-1:0];
            end
            else if (!t4_reg[i][F-1])
            begin
                seg5_next[i] = SEG_HIGH;
                fac5_next[i] = '0;
            end
            else if (t3x < {ONE, 1'b0})
            begin
                seg5_next[i] = SEG_FALL;
                fac5_next[i] = r6[W-1:0];
            end
            else
            begin
                seg5_next[i] = SEG_LOW;
                fac5_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        logic [W:0] c_a;
        for (int i = 0; i < 3; i++)
        begin
            case (seg6_reg[i])
                SEG_RISE, SEG_FALL: c_a = {1'b0, lo6_reg} + {1'b0, m6_reg[i]};
                SEG_HIGH:           c_a = {1'b0, hi6_reg};
                default:            c_a = {1'b0, lo6_reg};
            endcase
            if (gray6_reg)
            begin
                c7_next[i] = l6_reg;
            end
            else
            begin
                c7_next[i] = (c_a > {1'b0, ONE}) ? ONE : c_a[W-1:0];
            end
        end
    end

    always_comb
    begin
        logic [F+8:0] p;
        logic [8:0]   v;
        for (int i = 0; i < 3; i++)
        begin
            p = {c7_reg[i], 8'h00} - (F+9)'(c7_reg[i]) + (F+9)'(HALF);
            v = p[F+8:F];
            b8_next[i] = (v > 9'd255) ? 8'hFF : v[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_reg    <= h_x[F+15:16];
            s1_reg    <= div_ffff(s_x);
            l1_reg    <= div_ffff(l_x);
            gray1_reg <= (sat == 16'd0);

            h2_reg    <= h1_reg;
            s2_reg    <= s1_reg;
            l2_reg    <= l1_reg;
            ls2_reg   <= fx_mul(l1_reg, s1_reg);
            gray2_reg <= gray1_reg;

            hi3_reg   <= hi3_next;
            l3_reg    <= l2_reg;
            t3_reg[0] <= h2_reg + THIRD;
            t3_reg[1] <= h2_reg;
            t3_reg[2] <= h2_reg + REST_THIRD;
            gray3_reg <= gray2_reg;

            lo4_reg   <= lo4_next;
            hi4_reg   <= hi3_reg;
            span4_reg <= span4_next;
            l4_reg    <= l3_reg;
            t4_reg    <= t3_reg;
            gray4_reg <= gray3_reg;

            seg5_reg  <= seg5_next;
            fac5_reg  <= fac5_next;
            lo5_reg   <= lo4_reg;
            hi5_reg   <= hi4_reg;
            span5_reg <= span4_reg;
            l5_reg    <= l4_reg;
            gray5_reg <= gray4_reg;

            for (int i = 0; i < 3; i++)
            begin
                m6_reg[i] <= fx_mul(span5_reg, fac5_reg[i]);
            end
            seg6_reg  <= seg5_reg;
            lo6_reg   <= lo5_reg;
            hi6_reg   <= hi5_reg;
            l6_reg    <= l5_reg;
            gray6_reg <= gray5_reg;

            c7_reg    <= c7_next;
            b8_reg    <= b8_next;
        end
    end

    assign red   = b8_reg[0];
    assign green = b8_reg[1];
    assign blue  = b8_reg[2];

endmodule

FILE: bench/rgb_hsl_checker.sv
`timescale 1ns / 1ps

module rgb_hsl_checker #(
    parameter int FRACTION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        operation,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [15:0] hue_in,
    input  logic [15:0] sat_in,
    input  logic [15:0] light_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  red_out,
    input  logic [7:0]  green_out,
    input  logic [7:0]  blue_out,
    input  logic [15:0] hue_out,
    input  logic [15:0] sat_out,
    input  logic [15:0] light_out,
    output int          mismatch_count,
    output int          pending_count
);

    localparam longint unsigned ONE = 64'd1 << FRACTION_BITS;
    localparam longint unsigned HALF = 64'd1 << (FRACTION_BITS - 1);
    localparam longint unsigned THIRD = (ONE + 1) / 3;
    localparam longint unsigned TWO_THIRDS = (2 * ONE + 1) / 3;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] light;
    } pixel_t;

    pixel_t expected_pixels[$];

    function automatic longint unsigned fx_product(longint unsigned a, longint unsigned b);
        return (a * b + HALF) >> FRACTION_BITS;
    endfunction

    function automatic longint unsigned channel_level(longint unsigned lo,
                                                      longint unsigned hi,
                                                      longint unsigned t);
        longint unsigned span;
        longint unsigned c;
        longint unsigned rest;
        span = (hi > lo) ? hi - lo : 0;
        t = t & (ONE - 1);
        if (6 * t < ONE)
            c = lo + fx_product(span, 6 * t);
        else if (2 * t < ONE)
            c = hi;
        else if (3 * t < 2 * ONE)
        begin
            rest = (TWO_THIRDS > t) ? TWO_THIRDS - t : 0;
            c = lo + fx_product(span, 6 * rest);
        end
        else
            c = lo;
        return (c > ONE) ? ONE : c;
    endfunction

    function automatic logic [7:0] level_to_byte(longint unsigned c);
        longint unsigned v;
        v = (c * 255 + HALF) >> FRACTION_BITS;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic pixel_t convert_pixel(rhc_pkg::op_t op, logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b, logic [15:0] hue,
                                             logic [15:0] sat, logic [15:0] lig);
        pixel_t p;
        int mx, mn, del, sum, den, num;
        longint unsigned q, h, s, l, hi, lo, ls;
        p = '0;
        if (op == rhc_pkg::OP_RGB2HSL)
        begin
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            del = mx - mn;
            sum = mx + mn;
            q = (longint'(sum) * 257 + 1) / 2;
            p.light = q[15:0];
            if (del != 0)
            begin
                den = (sum < 255) ? sum : 510 - sum;
                q = (longint'(del) * 65535 + den / 2) / den;
                if (q > 65535) q = 65535;
                p.sat = q[15:0];
                if (r == mx) num = int'(g) - int'(b);
                else if (g == mx) num = 2 * del + (int'(b) - int'(r));
                else num = 4 * del + (int'(r) - int'(g));
                if (num < 0) num += 6 * del;
                q = (longint'(num) * 65536 + 3 * del) / (6 * del);
                p.hue = q[15:0];
            end
        end
        else
        begin
            h = ((longint'(hue) << FRACTION_BITS) + 32768) >> 16;
            s = ((longint'(sat) << FRACTION_BITS) + 32767) / 65535;
            l = ((longint'(lig) << FRACTION_BITS) + 32767) / 65535;
            h = h & (ONE - 1);
            if (sat == 0)
            begin
                p.red = level_to_byte(l);
                p.green = p.red;
                p.blue = p.red;
            end
            else
            begin
                ls = fx_product(l, s);
                if (l < HALF)
                    hi = l + ls;
                else
                    hi = (l + s > ls) ? l + s - ls : 0;
                if (hi > ONE) hi = ONE;
                lo = (2 * l > hi) ? 2 * l - hi : 0;
                if (lo > ONE) lo = ONE;
                p.red = level_to_byte(channel_level(lo, hi, h + THIRD));
                p.green = level_to_byte(channel_level(lo, hi, h));
                p.blue = level_to_byte(channel_level(lo, hi, h + ONE - THIRD));
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        pixel_t got;
        if (!rst_n)
        begin
            mismatch_count <= 0;
            pending_count <= 0;
            expected_pixels.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{red_out, green_out, blue_out, hue_out, sat_out, light_out};
                if (expected_pixels.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result beat %p", got);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want !== got)
                    begin
                        if (mismatch_count < 10)
                            $display("result mismatch: expected %p, actual %p", want, got);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(convert_pixel(rhc_pkg::op_t'(operation),
                                                        red_in, green_in, blue_in,
                                                        hue_in, sat_in, light_in));
            pending_count <= expected_pixels.size();
        end
    end

endmodule

FILE: bench/rgb_hsl_converter_tb.sv
`timescale 1ns / 1ps

module rgb_hsl_converter_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [7:0]  red_in, green_in, blue_in;
    logic [15:0] hue_in, sat_in, light_in;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  red_out, green_out, blue_out;
    logic [15:0] hue_out, sat_out, light_out;
    int          mismatch_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    bit          hold_off_start;
    bit          hold_off_done;
    bit          done;

    rgb_hsl_converter dut (.*);
    rgb_hsl_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_pixel(rhc_pkg::op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [15:0] h, logic [15:0] s, logic [15:0] l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        red_in <= r; green_in <= g; blue_in <= b;
        hue_in <= h; sat_in <= s; light_in <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        logic [15:0] s;
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        s = 16'($urandom);
        case ($urandom_range(7))
            0: g = r;
            1: begin g = r; b = r; end
            2: s = '0;
            3: b = g;
            default: ;
        endcase
        send_pixel(rhc_pkg::op_t'($urandom_range(1)), r, g, b, 16'($urandom), s,
                   16'($urandom));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= 0;
            hold_off_done <= 1'b0;
        end
        else if (hold_off_start && !hold_off_done)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= 199;
            hold_off_done <= 1'b1;
        end
        else if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        int unsigned t;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = rhc_pkg::OP_RGB2HSL;
        red_in = '0; green_in = '0; blue_in = '0;
        hue_in = '0; sat_in = '0; light_in = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_start = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd0, 8'd0, 8'd0, '1, '1, '1);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd255, 8'd255, 8'd255, '0, '0, '0);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd128, 8'd128, 8'd128, '0, '0, '0);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd255, 8'd0, 8'd0, '0, '0, '0);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd0, 8'd255, 8'd0, '0, '0, '0);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd0, 8'd0, 8'd255, '0, '0, '0);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd255, 8'd0, 8'd1, '0, '0, '0);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd255, 8'd255, 8'd0, '0, '0, '0);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd255, 8'd254, 8'd254, '0, '0, '0);
        send_pixel(rhc_pkg::OP_RGB2HSL, 8'd1, 8'd0, 8'd0, '0, '0, '0);
        send_pixel(rhc_pkg::OP_HSL2RGB, '1, '1, '1, 16'h0000, 16'h0000, 16'h8000);
        send_pixel(rhc_pkg::OP_HSL2RGB, '0, '0, '0, 16'h0000, 16'hFFFF, 16'h8000);
        send_pixel(rhc_pkg::OP_HSL2RGB, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_pixel(rhc_pkg::OP_HSL2RGB, '0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(rhc_pkg::OP_HSL2RGB, '0, '0, '0, 16'h5555, 16'hFFFF, 16'h0000);
        send_pixel(rhc_pkg::OP_HSL2RGB, '0, '0, '0, 16'hAAAA, 16'h0001, 16'hFFFF);
        send_pixel(rhc_pkg::OP_HSL2RGB, '0, '0, '0, 16'h2AAB, 16'h8000, 16'h4000);
        send_pixel(rhc_pkg::OP_HSL2RGB, '0, '0, '0, 16'hFFFF, 16'h0000, 16'hFFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 59 : 30) : 0;
            recv_stall_pct = (phase == 2) ? 59 : ((phase == 3) ? 30 : 0);
            for (int n = 0; n < 500; n++)
            begin
                if (phase == 0 && n == 100)
                    hold_off_start <= 1'b1;
                send_random_pixel();
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        t = 0;
        while (pending_count != 0 && t < 100000)
        begin
            @(posedge clk);
            t++;
        end
        repeat (40) @(posedge clk);
        done = 1'b1;
        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        if (!done)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
